### sv/pivf_pkg.sv
`default_nettype none

package pivf_pkg;

  // field widths
  localparam int COORD_W   = 32;
  localparam int QUAT_W    = 16;
  localparam int RANGE_W   = 31;
  localparam int TAN_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = RANGE_W;

  // fixed-point scaling
  localparam int TAN_FRAC_BITS  = 16;
  localparam int AXIS_DROP_BITS = 14;

  // internal widths
  localparam int D_W      = COORD_W + 1;             // camera-to-point offset
  localparam int QPROD_W  = 2 * QUAT_W;              // quaternion product
  localparam int QF_W     = QPROD_W + 3;             // axis entry before the drop
  localparam int AXIS_W   = QF_W - AXIS_DROP_BITS;   // axis entry
  localparam int SQ_W     = 2 * RANGE_W;             // square of a component
  localparam int SUM_W    = SQ_W + 2;                // squared length
  localparam int PROD_W   = D_W + AXIS_W;            // offset times axis entry
  localparam int DOT_W    = PROD_W + 2;              // dot product
  localparam int DF_LO_W  = (DOT_W - 1) / 2;
  localparam int DF_HI_W  = DOT_W - 1 - DF_LO_W;
  localparam int PLO_W    = TAN_W + DF_LO_W;
  localparam int PHI_W    = TAN_W + DF_HI_W;
  localparam int RHS_W    = TAN_W + DOT_W;

  localparam logic signed [QF_W-1:0] QUAT_ONE = QF_W'(64'sd1 <<< (2 * (QUAT_W - 2)));

  // register reset values
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = RANGE_W'(6553600);
  localparam logic [TAN_W-1:0]   TAN_HALF_H_RST = TAN_W'(37837);
  localparam logic [TAN_W-1:0]   TAN_HALF_V_RST = TAN_W'(23853);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAN_HALF_H = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TAN_HALF_V = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    REASON_INSIDE = 3'd0,
    REASON_NEAR   = 3'd1,
    REASON_FAR    = 3'd2,
    REASON_BEHIND = 3'd3,
    REASON_HORIZ  = 3'd4,
    REASON_VERT   = 3'd5
  } reason_t;

endpackage

`default_nettype wire

### sv/pivf_if.sv
`default_nettype none

interface pivf_in_if;
  import pivf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic signed [COORD_W-1:0] cam_x;
  logic signed [COORD_W-1:0] cam_y;
  logic signed [COORD_W-1:0] cam_z;
  logic signed [QUAT_W-1:0]  quat_w;
  logic signed [QUAT_W-1:0]  quat_x;
  logic signed [QUAT_W-1:0]  quat_y;
  logic signed [QUAT_W-1:0]  quat_z;

  modport source (
    output valid, point_x, point_y, point_z, cam_x, cam_y, cam_z,
           quat_w, quat_x, quat_y, quat_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, cam_x, cam_y, cam_z,
           quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

interface pivf_out_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic [2:0] reject_reason;

  modport source (output valid, inside_res, reject_reason, input ready);
  modport sink   (input valid, inside_res, reject_reason, output ready);
endinterface

`default_nettype wire

### sv/point_in_view_frustum_test.sv
// point in view frustum test
// in_ch carries one word per test: point, camera origin and a unit camera
// quaternion in Q2.14. out_ch returns inside_res and reject_reason for each
// word, in acceptance order (0 inside, 1 too near, 2 too far, 3 behind,
// 4 horizontal, 5 vertical).
// cfg_we/cfg_idx/cfg_wdata write max_range, tan_half_h and tan_half_v; write
// them only while no test is in flight. Other indexes are ignored.
// six register stages: offset and quaternion products, magnitudes, squares
// and axes, range sum and axis products, dot products, tangent partial
// products, final compare. A word moves through the stages in order, and
// one word can be taken every cycle unless a full pipeline is stalled.
// when out_ch is stalled, each stage holds and bubbles close up; in_ch.ready
// drops only once every stage holds a word.
// reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: range 100.0, tangents 0.5773 and 0.3640.
`default_nettype none

module point_in_view_frustum_test (
  input  wire                          clk,
  input  wire                          rst_n,
  pivf_in_if.sink                      in_ch,
  pivf_out_if.source                   out_ch,
  input  wire                          cfg_we,
  input  wire [pivf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire [pivf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pivf_pkg::*;

  localparam int NSTAGE = 6;

  function automatic logic signed [AXIS_W-1:0] drop(input logic signed [QF_W-1:0] v);
    logic signed [QF_W-1:0] s;
    s = v >>> AXIS_DROP_BITS;
    return s[AXIS_W-1:0];
  endfunction

  // configuration
  logic [RANGE_W-1:0] max_range_r;
  logic [TAN_W-1:0]   tan_h_r;
  logic [TAN_W-1:0]   tan_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r <= MAX_RANGE_RST;
      tan_h_r     <= TAN_HALF_H_RST;
      tan_v_r     <= TAN_HALF_V_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_RANGE:  max_range_r <= cfg_wdata[RANGE_W-1:0];
        CFG_TAN_HALF_H: tan_h_r     <= cfg_wdata[TAN_W-1:0];
        CFG_TAN_HALF_V: tan_v_r     <= cfg_wdata[TAN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic [NSTAGE:1] v_r;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !v_r[NSTAGE] || out_ch.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_ch.valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = en[1];

  // stage 1: offset and quaternion products
  logic signed [D_W-1:0]     s1_d_r [3];
  logic signed [QPROD_W-1:0] s1_xx_r, s1_yy_r, s1_zz_r, s1_xy_r, s1_xz_r, s1_yz_r;
  logic signed [QPROD_W-1:0] s1_wx_r, s1_wy_r, s1_wz_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d_r[0] <= D_W'(in_ch.point_x) - D_W'(in_ch.cam_x);
      s1_d_r[1] <= D_W'(in_ch.point_y) - D_W'(in_ch.cam_y);
      s1_d_r[2] <= D_W'(in_ch.point_z) - D_W'(in_ch.cam_z);
      s1_xx_r   <= in_ch.quat_x * in_ch.quat_x;
      s1_yy_r   <= in_ch.quat_y * in_ch.quat_y;
      s1_zz_r   <= in_ch.quat_z * in_ch.quat_z;
      s1_xy_r   <= in_ch.quat_x * in_ch.quat_y;
      s1_xz_r   <= in_ch.quat_x * in_ch.quat_z;
      s1_yz_r   <= in_ch.quat_y * in_ch.quat_z;
      s1_wx_r   <= in_ch.quat_w * in_ch.quat_x;
      s1_wy_r   <= in_ch.quat_w * in_ch.quat_y;
      s1_wz_r   <= in_ch.quat_w * in_ch.quat_z;
    end
  end

  // stage 2: magnitudes, early rejects, squares, axes
  logic [D_W-1:0]           mag_d [3];
  logic                     zero_d;
  logic                     far_comp;
  reason_t                  s2_reason_nxt;
  logic signed [QF_W-1:0]   ax_full [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = s1_d_r[i][D_W-1] ? D_W'(-s1_d_r[i]) : D_W'(s1_d_r[i]);
    end
    zero_d   = (s1_d_r[0] == '0) && (s1_d_r[1] == '0) && (s1_d_r[2] == '0);
    far_comp = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (mag_d[i] > D_W'(max_range_r)) far_comp = 1'b1;
    end
    if (zero_d)        s2_reason_nxt = REASON_NEAR;
    else if (far_comp) s2_reason_nxt = REASON_FAR;
    else               s2_reason_nxt = REASON_INSIDE;

    // right, up, forward rows
    ax_full[0] = QUAT_ONE - ((QF_W'(s1_yy_r) + QF_W'(s1_zz_r)) <<< 1);
    ax_full[1] = (QF_W'(s1_xy_r) + QF_W'(s1_wz_r)) <<< 1;
    ax_full[2] = (QF_W'(s1_xz_r) - QF_W'(s1_wy_r)) <<< 1;
    ax_full[3] = (QF_W'(s1_xy_r) - QF_W'(s1_wz_r)) <<< 1;
    ax_full[4] = QUAT_ONE - ((QF_W'(s1_xx_r) + QF_W'(s1_zz_r)) <<< 1);
    ax_full[5] = (QF_W'(s1_yz_r) + QF_W'(s1_wx_r)) <<< 1;
    ax_full[6] = (QF_W'(s1_xz_r) + QF_W'(s1_wy_r)) <<< 1;
    ax_full[7] = (QF_W'(s1_yz_r) - QF_W'(s1_wx_r)) <<< 1;
    ax_full[8] = QUAT_ONE - ((QF_W'(s1_xx_r) + QF_W'(s1_yy_r)) <<< 1);
  end

  logic signed [D_W-1:0]    s2_d_r [3];
  logic [SQ_W-1:0]          s2_sq_r [3];
  logic [SQ_W-1:0]          s2_lim_r;
  logic signed [AXIS_W-1:0] s2_ax_r [9];
  reason_t                  s2_reason_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_d_r[i]  <= s1_d_r[i];
        // only read when every magnitude is within range
        s2_sq_r[i] <= SQ_W'(mag_d[i][RANGE_W-1:0]) * SQ_W'(mag_d[i][RANGE_W-1:0]);
      end
      s2_lim_r <= SQ_W'(max_range_r) * SQ_W'(max_range_r);
      for (int i = 0; i < 9; i++) begin
        s2_ax_r[i] <= drop(ax_full[i]);
      end
      s2_reason_r <= s2_reason_nxt;
    end
  end

  // stage 3: squared length compare, axis products
  logic [SUM_W-1:0] len_sq;
  reason_t          s3_reason_nxt;

  always_comb begin
    len_sq = SUM_W'(s2_sq_r[0]) + SUM_W'(s2_sq_r[1]) + SUM_W'(s2_sq_r[2]);
    s3_reason_nxt = s2_reason_r;
    if (s2_reason_r == REASON_INSIDE && len_sq > SUM_W'(s2_lim_r)) begin
      s3_reason_nxt = REASON_FAR;
    end
  end

  logic signed [PROD_W-1:0] s3_prod_r [9];
  reason_t                  s3_reason_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          s3_prod_r[3*a+i] <= PROD_W'(s2_d_r[i]) * PROD_W'(s2_ax_r[3*a+i]);
        end
      end
      s3_reason_r <= s3_reason_nxt;
    end
  end

  // stage 4: dot products
  logic signed [DOT_W-1:0] s4_dr_r, s4_du_r, s4_df_r;
  reason_t                 s4_reason_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_dr_r <= DOT_W'(s3_prod_r[0]) + DOT_W'(s3_prod_r[1]) + DOT_W'(s3_prod_r[2]);
      s4_du_r <= DOT_W'(s3_prod_r[3]) + DOT_W'(s3_prod_r[4]) + DOT_W'(s3_prod_r[5]);
      s4_df_r <= DOT_W'(s3_prod_r[6]) + DOT_W'(s3_prod_r[7]) + DOT_W'(s3_prod_r[8]);
      s4_reason_r <= s3_reason_r;
    end
  end

  // stage 5: behind test, side magnitudes, tangent partial products
  reason_t          s5_reason_nxt;
  logic [DOT_W-1:0] mag_dr, mag_du;

  always_comb begin
    s5_reason_nxt = s4_reason_r;
    if (s4_reason_r == REASON_INSIDE && (s4_df_r[DOT_W-1] || s4_df_r == '0)) begin
      s5_reason_nxt = REASON_BEHIND;
    end
    mag_dr = s4_dr_r[DOT_W-1] ? DOT_W'(-s4_dr_r) : DOT_W'(s4_dr_r);
    mag_du = s4_du_r[DOT_W-1] ? DOT_W'(-s4_du_r) : DOT_W'(s4_du_r);
  end

  logic [DOT_W-1:0] s5_mag_dr_r, s5_mag_du_r;
  logic [PLO_W-1:0] s5_ph_lo_r, s5_pv_lo_r;
  logic [PHI_W-1:0] s5_ph_hi_r, s5_pv_hi_r;
  reason_t          s5_reason_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_mag_dr_r <= mag_dr;
      s5_mag_du_r <= mag_du;
      // forward dot is positive whenever these are used
      s5_ph_lo_r  <= PLO_W'(tan_h_r) * PLO_W'(s4_df_r[DF_LO_W-1:0]);
      s5_ph_hi_r  <= PHI_W'(tan_h_r) * PHI_W'(s4_df_r[DOT_W-2:DF_LO_W]);
      s5_pv_lo_r  <= PLO_W'(tan_v_r) * PLO_W'(s4_df_r[DF_LO_W-1:0]);
      s5_pv_hi_r  <= PHI_W'(tan_v_r) * PHI_W'(s4_df_r[DOT_W-2:DF_LO_W]);
      s5_reason_r <= s5_reason_nxt;
    end
  end

  // stage 6: tangent compares, output register
  logic [RHS_W-1:0] rhs_h, rhs_v, lhs_h, lhs_v;
  logic             beyond_h, beyond_v;
  reason_t          s6_reason_nxt;

  always_comb begin
    rhs_h = (RHS_W'(s5_ph_hi_r) << DF_LO_W) + RHS_W'(s5_ph_lo_r);
    rhs_v = (RHS_W'(s5_pv_hi_r) << DF_LO_W) + RHS_W'(s5_pv_lo_r);
    lhs_h = RHS_W'({s5_mag_dr_r, {TAN_FRAC_BITS{1'b0}}});
    lhs_v = RHS_W'({s5_mag_du_r, {TAN_FRAC_BITS{1'b0}}});
    beyond_h = lhs_h > rhs_h;
    beyond_v = lhs_v > rhs_v;
    s6_reason_nxt = s5_reason_r;
    if (s5_reason_r == REASON_INSIDE) begin
      if (beyond_h)      s6_reason_nxt = REASON_HORIZ;
      else if (beyond_v) s6_reason_nxt = REASON_VERT;
    end
  end

  reason_t s6_reason_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_reason_r <= s6_reason_nxt;
    end
  end

  assign out_ch.valid         = v_r[NSTAGE];
  assign out_ch.reject_reason = s6_reason_r;
  assign out_ch.inside_res    = (s6_reason_r == REASON_INSIDE);

endmodule

`default_nettype wire

### sv/pivf_checker.sv
`default_nettype none

module pivf_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       inside_res,
  input wire [2:0] reject_reason
);
  import pivf_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reject_reason) && $stable(inside_res))
    else $error("stalled result changed");

  // flag and reason agree
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (inside_res == (reject_reason == REASON_INSIDE)))
    else $error("inside flag disagrees with reason");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (reject_reason <= REASON_VERT))
    else $error("reason code out of range");

  // pipeline cannot be backed up while the output stage is empty
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_in_view_frustum_test pivf_checker u_pivf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .inside_res    (out_ch.inside_res),
  .reject_reason (out_ch.reject_reason)
);

`default_nettype wire
